// ===== rtl/utpt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utpt_pkg
// Shared types and constants of the card presence table.
// ----------------------------------------------------------------------------
package utpt_pkg;

    localparam int UID_W       = 32;
    localparam int SLOT_IDX_W  = 4;
    localparam int OCC_CNT_W   = 5;
    localparam int ACTION_W    = 2;

    localparam logic [UID_W-1:0] KNOWN_UID_RESET = 32'h770F_4363;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CHECK_IN  = 2'd0,
        ACT_CHECK_OUT = 2'd1,
        ACT_FULL      = 2'd2
    } action_t;

endpackage : utpt_pkg
`default_nettype wire

// ===== rtl/uid_toggle_presence_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uid_toggle_presence_table
// Check-in / check-out presence table keyed by 32-bit card identifiers.
// ----------------------------------------------------------------------------
// Each request carries one card identifier. The block compares it against
// every valid slot at once: a hit frees that slot (check-out), a miss stores
// the identifier in the lowest free slot (check-in), and a miss with no free
// slot changes nothing and reports the store as full. One request enters per
// clock. The accepting edge loads the input register, and the next edge loads
// the result register, so the result appears on the result ports after that
// edge, marked by a one cycle result_valid strobe, and holds there until the
// next result replaces it. The receiver cannot stall, so busy stays low and a
// new request can be issued every cycle. The compare array, the free-slot
// encoder and the count update sit in one stage between those two registers,
// which also writes the table, so back-to-back requests always see the effect
// of the one before.
// ----------------------------------------------------------------------------
module uid_toggle_presence_table #(
    parameter int SLOT_COUNT = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // request channel
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [utpt_pkg::UID_W-1:0]         card_uid,
    // result channel
    output logic                                    result_valid,
    output logic [utpt_pkg::ACTION_W-1:0]           action,
    output logic [utpt_pkg::SLOT_IDX_W-1:0]         slot_index,
    output logic [utpt_pkg::OCC_CNT_W-1:0]          occupied_count,
    output logic                                    is_known_item,
    // configuration port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [2:0]                         paddr,
    input  wire logic [31:0]                        pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready
);
    import utpt_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);

    // ------------------------------------------------------------------
    // Configuration: one register, known_uid_reg, at byte addresses 0 to 3.
    // ------------------------------------------------------------------
    logic             cfg_wr;
    logic             cfg_sel_known;
    logic [UID_W-1:0] known_uid_reg;

    assign pready        = 1'b1;
    assign cfg_sel_known = (paddr[2] == 1'b0);
    assign cfg_wr        = psel && penable && pwrite && pready;
    assign prdata        = cfg_sel_known ? known_uid_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            known_uid_reg <= KNOWN_UID_RESET;
        end
        else if (cfg_wr && cfg_sel_known)
        begin
            known_uid_reg <= pwdata;
        end
    end

    // ------------------------------------------------------------------
    // Input register: capture the request.
    // ------------------------------------------------------------------
    logic             in_valid_reg;
    logic [UID_W-1:0] in_uid_reg;
    logic             req_accept;

    assign busy       = 1'b0;
    assign req_accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= req_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            in_uid_reg <= card_uid;
        end
    end

    // ------------------------------------------------------------------
    // Slot table: keys carry no reset, valid marks and count do.
    // ------------------------------------------------------------------
    logic [UID_W-1:0]      slot_key_reg [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] slot_valid_reg;
    logic [SLOT_COUNT-1:0] slot_valid_next;
    logic [CNT_W-1:0]      valid_count_reg;
    logic [CNT_W-1:0]      valid_count_next;

    logic             hit_found;
    logic [IDX_W-1:0] hit_index;
    logic             free_found;
    logic [IDX_W-1:0] free_index;

    utpt_match #(
        .SLOT_COUNT (SLOT_COUNT),
        .IDX_W      (IDX_W)
    ) u_match (
        .uid        (in_uid_reg),
        .slot_valid (slot_valid_reg),
        .slot_key   (slot_key_reg),
        .hit_found  (hit_found),
        .hit_index  (hit_index),
        .free_found (free_found),
        .free_index (free_index)
    );

    // Decide the action and the next table state.
    action_t          action_next;
    logic [IDX_W-1:0] slot_sel;
    logic             key_wr;

    always_comb
    begin
        slot_valid_next  = slot_valid_reg;
        valid_count_next = valid_count_reg;
        action_next      = ACT_FULL;
        slot_sel         = '0;
        key_wr           = 1'b0;
        if (hit_found)
        begin
            // check-out: drop the matching slot
            slot_valid_next[hit_index] = 1'b0;
            if (valid_count_reg != '0)
            begin
                valid_count_next = valid_count_reg - CNT_W'(1);
            end
            action_next = ACT_CHECK_OUT;
            slot_sel    = hit_index;
        end
        else if (free_found)
        begin
            // check-in: claim the lowest free slot
            slot_valid_next[free_index] = 1'b1;
            valid_count_next            = valid_count_reg + CNT_W'(1);
            action_next                 = ACT_CHECK_IN;
            slot_sel                    = free_index;
            key_wr                      = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg  <= '0;
            valid_count_reg <= '0;
        end
        else if (in_valid_reg)
        begin
            slot_valid_reg  <= slot_valid_next;
            valid_count_reg <= valid_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg && key_wr)
        begin
            slot_key_reg[free_index] <= in_uid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Result register: fit index and count to the field widths.
    // ------------------------------------------------------------------
    logic [IDX_W+SLOT_IDX_W-1:0] slot_sel_ext;
    logic [CNT_W+OCC_CNT_W-1:0]  count_ext;

    assign slot_sel_ext = {{SLOT_IDX_W{1'b0}}, slot_sel};
    assign count_ext    = {{OCC_CNT_W{1'b0}}, valid_count_next};

    logic                  result_valid_reg;
    logic [ACTION_W-1:0]   action_reg;
    logic [SLOT_IDX_W-1:0] slot_index_reg;
    logic [OCC_CNT_W-1:0]  occupied_count_reg;
    logic                  is_known_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            action_reg         <= action_next;
            slot_index_reg     <= slot_sel_ext[SLOT_IDX_W-1:0];
            occupied_count_reg <= count_ext[OCC_CNT_W-1:0];
            is_known_item_reg  <= (in_uid_reg == known_uid_reg);
        end
    end

    assign result_valid   = result_valid_reg;
    assign action         = action_reg;
    assign slot_index     = slot_index_reg;
    assign occupied_count = occupied_count_reg;
    assign is_known_item  = is_known_item_reg;

endmodule : uid_toggle_presence_table
`default_nettype wire

// ===== rtl/utpt_match.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utpt_match
// Parallel key compare against all valid slots, plus lowest-index priority
// encoders for the first matching slot and the first free slot.
// ----------------------------------------------------------------------------
module utpt_match #(
    parameter int SLOT_COUNT = 16,
    parameter int IDX_W      = 4
) (
    input  wire logic [utpt_pkg::UID_W-1:0] uid,
    input  wire logic [SLOT_COUNT-1:0]      slot_valid,
    input  wire logic [utpt_pkg::UID_W-1:0] slot_key [SLOT_COUNT],
    output logic                            hit_found,
    output logic [IDX_W-1:0]                hit_index,
    output logic                            free_found,
    output logic [IDX_W-1:0]                free_index
);
    import utpt_pkg::*;

    logic [SLOT_COUNT-1:0] hit_vec;

    always_comb
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            hit_vec[i] = slot_valid[i] && (slot_key[i] == uid);
        end
    end

    // Scan from the top down so the lowest index wins.
    always_comb
    begin
        hit_found  = 1'b0;
        hit_index  = '0;
        free_found = 1'b0;
        free_index = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                hit_found = 1'b1;
                hit_index = IDX_W'(i);
            end
            if (!slot_valid[i])
            begin
                free_found = 1'b1;
                free_index = IDX_W'(i);
            end
        end
    end

endmodule : utpt_match
`default_nettype wire
